// ----- sv/rxclb_pkg.sv -----
`default_nettype none
package rxclb_pkg;

  localparam int RING_DEPTH = 64;
  localparam int LINE_DEPTH = 32;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // request kinds on the slave side (tuser)
  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;    // capture the receive byte
    logic recv_commit; // push latched byte into the ring, load stored flag
    logic ring_read;   // read ring at read pointer, advance pointer
    logic line_write;  // append ring byte to the line (if room)
    logic line_read;   // read line entry at emit index
    logic idx_step;    // advance emit index
    logic line_clear;  // drop the assembled line
    logic load_nocmd;  // load "no command" result
    logic load_empty;  // load empty-command result
    logic load_byte;   // load one command byte
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_op;
    logic ring_empty;
    logic is_eol;
    logic line_nonempty;
    logic cmd_len_zero;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- sv/rxclb_ctrl.sv -----
`default_nettype none
module rxclb_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_valid,
  output logic              s_ready,
  input  rxclb_pkg::status_t st,
  output rxclb_pkg::cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_RECV      = 7'b0000010,
    S_DRAIN_RD  = 7'b0000100,
    S_DRAIN_CHK = 7'b0001000,
    S_NOCMD     = 7'b0010000,
    S_EMIT_RD   = 7'b0100000,
    S_EMIT_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          if (st.in_op == rxclb_pkg::OP_RECV) begin
            cmd.latch_in = 1'b1;
            state_next   = S_RECV;
          end else begin
            state_next = S_DRAIN_RD;
          end
        end
      end
      S_RECV: begin
        if (st.out_free) begin
          cmd.recv_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_DRAIN_RD: begin
        if (st.ring_empty) begin
          state_next = S_NOCMD;
        end else begin
          cmd.ring_read = 1'b1;
          state_next    = S_DRAIN_CHK;
        end
      end
      S_DRAIN_CHK: begin
        if (st.is_eol) begin
          state_next = st.line_nonempty ? S_EMIT_RD : S_DRAIN_RD;
        end else begin
          cmd.line_write = 1'b1;
          state_next     = S_DRAIN_RD;
        end
      end
      S_NOCMD: begin
        if (st.out_free) begin
          cmd.load_nocmd = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        if (st.cmd_len_zero) begin
          if (st.out_free) begin
            cmd.load_empty = 1'b1;
            cmd.line_clear = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.line_read = 1'b1;
          state_next    = S_EMIT_OUT;
        end
      end
      S_EMIT_OUT: begin
        if (st.out_free) begin
          cmd.load_byte = 1'b1;
          if (st.emit_last) begin
            cmd.line_clear = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.idx_step = 1'b1;
            state_next   = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/rxclb_dp.sv -----
`default_nettype none
module rxclb_dp #(
  parameter int RING_DEPTH = rxclb_pkg::RING_DEPTH,
  parameter int LINE_DEPTH = rxclb_pkg::LINE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_op,
  input  wire  [7:0]          s_byte,
  output logic                m_valid,
  input  wire                 m_ready,
  output logic [1:0]          m_user,
  output logic [7:0]          m_data,
  output logic                m_last,
  input  rxclb_pkg::cmd_t     cmd,
  output rxclb_pkg::status_t  st
);

  localparam int RPW = $clog2(RING_DEPTH);
  localparam int LCW = $clog2(LINE_DEPTH);
  localparam logic [RPW-1:0] RING_LAST = RPW'(RING_DEPTH - 1);
  localparam logic [LCW-1:0] LINE_MAX  = LCW'(LINE_DEPTH - 1);

  logic [7:0]     ring [RING_DEPTH];
  logic [7:0]     line [LINE_DEPTH];
  logic [RPW-1:0] wp, rp, wp_inc, rp_inc;
  logic [LCW-1:0] line_count, idx, zpos, cmd_len;
  logic           zero_seen;
  logic [7:0]     rx_hold, ring_rdata, line_rdata;
  logic           ring_full;

  assign wp_inc    = (wp == RING_LAST) ? '0 : wp + 1'b1;
  assign rp_inc    = (rp == RING_LAST) ? '0 : rp + 1'b1;
  assign ring_full = (wp_inc == rp);
  assign cmd_len   = zero_seen ? zpos : line_count;

  assign st.in_op         = s_op;
  assign st.ring_empty    = (wp == rp);
  assign st.is_eol        = (ring_rdata == rxclb_pkg::CH_CR) ||
                            (ring_rdata == rxclb_pkg::CH_LF);
  assign st.line_nonempty = (line_count != '0);
  assign st.cmd_len_zero  = (cmd_len == '0);
  assign st.emit_last     = (idx == cmd_len - 1'b1);
  assign st.out_free      = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rx_hold <= s_byte;
    end
    if (cmd.recv_commit && !ring_full) begin
      ring[wp] <= rx_hold;
    end
    if (cmd.ring_read) begin
      ring_rdata <= ring[rp];
    end
    if (cmd.line_write && line_count < LINE_MAX) begin
      line[line_count] <= ring_rdata;
    end
    if (cmd.line_read) begin
      line_rdata <= line[idx];
    end
  end

  // pointers, line bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      line_count <= '0;
      zero_seen  <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd.recv_commit && !ring_full) begin
        wp <= wp_inc;
      end
      if (cmd.ring_read) begin
        rp <= rp_inc;
      end
      if (cmd.line_write && line_count < LINE_MAX) begin
        line_count <= line_count + 1'b1;
        if (ring_rdata == 8'h00 && !zero_seen) begin
          zero_seen <= 1'b1;
        end
      end
      if (cmd.idx_step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.line_clear) begin
        line_count <= '0;
        zero_seen  <= 1'b0;
        idx        <= '0;
      end
    end
  end

  // first zero byte position, recorded as the line is assembled
  always_ff @(posedge clk) begin
    if (cmd.line_write && line_count < LINE_MAX && ring_rdata == 8'h00 && !zero_seen) begin
      zpos <= line_count;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.recv_commit || cmd.load_nocmd || cmd.load_empty || cmd.load_byte) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.recv_commit) begin
      m_user <= {1'b0, !ring_full};
      m_data <= 8'h00;
      m_last <= 1'b1;
    end else if (cmd.load_nocmd) begin
      m_user <= 2'b00;
      m_data <= 8'h00;
      m_last <= 1'b1;
    end else if (cmd.load_empty) begin
      m_user <= 2'b10;
      m_data <= 8'h00;
      m_last <= 1'b1;
    end else if (cmd.load_byte) begin
      m_user <= 2'b10;
      m_data <= line_rdata;
      m_last <= st.emit_last;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rx_ring_command_line_buffer_top.sv -----
`default_nettype none
// Receive ring FIFO with command line assembler.
// Slave channel: one request per tvalid/tready handshake. tuser is the op
// (0 receive the byte in tdata, 1 read a pending command).
// Master channel: result items from a single output register.
// A receive request gives one result: tuser[0] says whether the byte went
// into the ring (the ring keeps at most RING_DEPTH-1 bytes), tlast = 1.
// A read request drains the ring into the line store byte by byte
// (registered ring read, then the check), until CR/LF ends a non-empty line
// or the ring runs dry. With no completed line one result is given with
// tuser = 0. Otherwise the command goes out byte by byte (line store read,
// then output load, held while the output stalls), tuser[1] = 1, tlast on
// the final byte; it stops before the first zero byte and an empty command
// is one zero byte.
// One request is in work at a time; a new one is taken as soon as the
// previous has loaded its last result, even while that result still waits.
// Master stall simply holds the output register and the controller.
// Reset (rst, synchronous) empties the ring and the line; no clearing pass.
module rx_ring_command_line_buffer_top #(
  parameter int RING_DEPTH = rxclb_pkg::RING_DEPTH,
  parameter int LINE_DEPTH = rxclb_pkg::LINE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire  [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  wire        s_axis_tuser,   // [0] op
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] command_byte
  output logic [1:0] m_axis_tuser,   // [0] stored, [1] command_valid
  output logic       m_axis_tlast    // last_byte
);

  rxclb_pkg::cmd_t    cmd;
  rxclb_pkg::status_t st;

  rxclb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  rxclb_dp #(
    .RING_DEPTH (RING_DEPTH),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_op    (s_axis_tuser),
    .s_byte  (s_axis_tdata),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_user  (m_axis_tuser),
    .m_data  (m_axis_tdata),
    .m_last  (m_axis_tlast),
    .cmd     (cmd),
    .st      (st)
  );

endmodule
`default_nettype wire
